// ----- rtl/rrfc_pkg.sv -----
// Shared types, constants and status codes of the reader response frame checker.
package rrfc_pkg;

	// Default geometry of the receive stream
	localparam int BUFFER_BYTES_DEF = 64;
	localparam int ACK_BYTES_DEF    = 6;

	// Byte position counter, wide enough for the largest buffer
	localparam int COUNT_W = 7;
	// Data window end: 8-bit length plus a small position offset
	localparam int WIN_W   = 9;

	// Status codes of one check
	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_SHORT   = 3'd1,
		ST_LCS_BAD = 3'd2,
		ST_DCS_BAD = 3'd3,
		ST_BEYOND  = 3'd4
	} status_t;

	// Request kinds
	typedef enum logic {
		REQ_BYTE  = 1'b0,
		REQ_CHECK = 1'b1
	} req_t;

	// Input item: one received byte or a check request
	typedef struct packed {
		logic       req_type;
		logic [7:0] rx_byte;
	} in_item_t;

	// Result item of one check
	typedef struct packed {
		status_t     frame_status;
		logic [7:0]  response_code;
		logic [31:0] card_uid;
	} out_item_t;

endpackage

// ----- rtl/rrfc_if.sv -----
// Valid/ready stream interfaces for the input and result channels.
interface rrfc_in_if;
	logic               valid;
	logic               ready;
	rrfc_pkg::in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface rrfc_out_if;
	logic                valid;
	logic                ready;
	rrfc_pkg::out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/reader_response_frame_checker_unit.sv -----
// Top level: running frame capture, length/data checksum check and result buffer.
//
//  channel | dir | payload                                   | transfer per
//  --------+-----+-------------------------------------------+------------------------
//  item    | in  | req_type, rx_byte                         | received byte or check
//  result  | out | frame_status, response_code, card_uid     | check request
//
// One item is taken in every cycle while the skid register is empty. A byte updates the running captures and
// the 8-bit sum in the cycle it is transferred; a check registers its result into
// the output register, or into the skid register behind it, and clears the captures at the same edge.
// Results queue in the output register and a skid register behind it; item
// ready drops only while both hold a result. Reset clears all captures.
module reader_response_frame_checker_unit #(
	parameter int BUFFER_BYTES = rrfc_pkg::BUFFER_BYTES_DEF,
	parameter int ACK_BYTES    = rrfc_pkg::ACK_BYTES_DEF
) (
	input logic         clk,
	input logic         arst_n,
	rrfc_in_if.sink     item,
	rrfc_out_if.source  result
);

	localparam int CW = rrfc_pkg::COUNT_W;
	localparam int WW = rrfc_pkg::WIN_W;

	localparam logic [CW-1:0] BUF_END   = CW'(BUFFER_BYTES);
	localparam logic [CW-1:0] POS_LEN   = CW'(ACK_BYTES + 3);
	localparam logic [CW-1:0] POS_LCS   = CW'(ACK_BYTES + 4);
	localparam logic [CW-1:0] POS_DATA  = CW'(ACK_BYTES + 5);
	localparam logic [CW-1:0] POS_CODE  = CW'(ACK_BYTES + 7);
	localparam logic [CW-1:0] POS_UID   = CW'(ACK_BYTES + 13);
	localparam logic [CW-1:0] MIN_BYTES = CW'(ACK_BYTES + 9);
	localparam logic [WW-1:0] BUF_END_W = WW'(BUFFER_BYTES);
	localparam logic [WW-1:0] POS_DATA_W = WW'(ACK_BYTES + 5);

	// Capture state
	logic [CW-1:0] count_q,    count_d;
	logic [7:0]    len_q,      len_d;
	logic [7:0]    lcs_q,      lcs_d;
	logic [7:0]    sum_q,      sum_d;
	logic [7:0]    dcs_q,      dcs_d;
	logic [7:0]    code_q,     code_d;
	logic [31:0]   uid_q,      uid_d;

	// Result buffer
	logic                out_valid_q;
	logic                skid_valid_q;
	rrfc_pkg::out_item_t out_q;
	rrfc_pkg::out_item_t skid_q;

	logic                in_xfer;
	logic                is_check;
	logic                push;
	logic                pop;
	logic [WW-1:0]       pos_w;
	logic [WW-1:0]       win_end;
	rrfc_pkg::out_item_t res;

	assign in_xfer  = item.valid && item.ready;
	assign is_check = (item.data.req_type == rrfc_pkg::REQ_CHECK);
	assign push     = in_xfer && is_check;
	assign pop      = out_valid_q && result.ready;

	assign item.ready   = !skid_valid_q;
	assign result.valid = out_valid_q;
	assign result.data  = out_q;

	// Current byte position and position of the data check byte
	assign pos_w   = WW'(count_q);
	assign win_end = POS_DATA_W + WW'(len_q);

	// Judge the frame held in the captures
	always_comb begin
		res.response_code = code_q;
		res.card_uid      = uid_q;
		priority if (count_q < MIN_BYTES) begin
			res.frame_status = rrfc_pkg::ST_SHORT;
		end else if (8'(~len_q + 8'd1) != lcs_q) begin
			res.frame_status = rrfc_pkg::ST_LCS_BAD;
		end else if (win_end >= BUF_END_W) begin
			res.frame_status = rrfc_pkg::ST_BEYOND;
		end else if (8'(~sum_q + 8'd1) != dcs_q) begin
			res.frame_status = rrfc_pkg::ST_DCS_BAD;
		end else begin
			res.frame_status = rrfc_pkg::ST_OK;
		end
	end

	// Next capture state for a byte transfer or a check
	always_comb begin
		count_d = count_q;
		len_d   = len_q;
		lcs_d   = lcs_q;
		sum_d   = sum_q;
		dcs_d   = dcs_q;
		code_d  = code_q;
		uid_d   = uid_q;
		if (in_xfer) begin
			if (is_check) begin
				count_d = '0;
				len_d   = '0;
				lcs_d   = '0;
				sum_d   = '0;
				dcs_d   = '0;
				code_d  = '0;
				uid_d   = '0;
			end else if (count_q < BUF_END) begin
				if (count_q == POS_LEN) begin
					len_d = item.data.rx_byte;
				end
				if (count_q == POS_LCS) begin
					lcs_d = item.data.rx_byte;
				end
				// running sum over the data window
				if (count_q >= POS_DATA && pos_w < win_end) begin
					sum_d = sum_q + item.data.rx_byte;
				end
				if (pos_w == win_end) begin
					dcs_d = item.data.rx_byte;
				end
				if (count_q == POS_CODE) begin
					code_d = item.data.rx_byte;
				end
				for (int k = 0; k < 4; k++) begin
					if (count_q == POS_UID + CW'(k)) begin
						uid_d[8*k +: 8] = item.data.rx_byte;
					end
				end
				count_d = count_q + CW'(1);
			end
		end
	end

	// Capture registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			len_q   <= '0;
			lcs_q   <= '0;
			sum_q   <= '0;
			dcs_q   <= '0;
			code_q  <= '0;
			uid_q   <= '0;
		end else begin
			count_q <= count_d;
			len_q   <= len_d;
			lcs_q   <= lcs_d;
			sum_q   <= sum_d;
			dcs_q   <= dcs_d;
			code_q  <= code_d;
			uid_q   <= uid_d;
		end
	end

	// Output register with skid entry behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (!out_valid_q || pop) begin
				if (skid_valid_q) begin
					out_valid_q  <= 1'b1;
					skid_valid_q <= push;
				end else begin
					out_valid_q  <= push;
				end
			end else if (push) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || pop) begin
			if (skid_valid_q) begin
				out_q  <= skid_q;
				skid_q <= res;
			end else begin
				out_q  <= res;
			end
		end else if (push) begin
			skid_q <= res;
		end
	end

`ifndef SYNTHESIS
	// Position counter saturates at the buffer end
	assert property (@(posedge clk) disable iff (!arst_n) count_q <= BUF_END)
		else $error("byte count beyond buffer end");

	// Skid entry only fills behind a held result
	assert property (@(posedge clk) disable iff (!arst_n) skid_valid_q |-> out_valid_q)
		else $error("skid entry holds a result while output register is empty");

	// A check clears the captures
	assert property (@(posedge clk) disable iff (!arst_n)
		push |=> (count_q == '0 && sum_q == '0 && uid_q == '0))
		else $error("captures not cleared after check");

	// A check into an empty buffer shows up on the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(push && !out_valid_q) |=> (out_valid_q && !skid_valid_q))
		else $error("check result lost");
`endif

endmodule

// ----- sim/rrfc_frame_mon.sv -----
// Passive monitor that predicts frame check results and compares them with the result channel.
module rrfc_frame_mon (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_ready,
	input  rrfc_pkg::in_item_t  in_data,
	input  logic                out_valid,
	input  logic                out_ready,
	input  rrfc_pkg::out_item_t out_data,
	output int                  fail_count,
	output int                  pending,
	output int                  n_checked,
	output logic [4:0]          status_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int BUF_BYTES = rrfc_pkg::BUFFER_BYTES_DEF;
	localparam int ACK_LEN   = rrfc_pkg::ACK_BYTES_DEF;
	localparam int P_LEN     = ACK_LEN + 3;
	localparam int P_LCS     = ACK_LEN + 4;
	localparam int P_DATA    = ACK_LEN + 5;
	localparam int P_CODE    = ACK_LEN + 7;
	localparam int P_UID     = ACK_LEN + 13;
	localparam int MIN_LEN   = ACK_LEN + 9;

	// Running frame captures, mirrored from the transfers on the item channel
	int          rx_count;
	logic [7:0]  len_b;
	logic [7:0]  lcs_b;
	logic [7:0]  data_sum;
	logic [7:0]  dcs_b;
	logic [7:0]  code_b;
	logic [31:0] uid_b;

	// Check results still owed by the block, oldest first
	rrfc_pkg::out_item_t due_results[$];

	task clear_frame();
		rx_count = 0;
		len_b    = '0;
		lcs_b    = '0;
		data_sum = '0;
		dcs_b    = '0;
		code_b   = '0;
		uid_b    = '0;
	endtask

	// Fold one received byte into the captures; bytes past the buffer are dropped
	task capture_byte(input logic [7:0] b);
		int pos;
		pos = rx_count;
		if (pos < BUF_BYTES) begin
			if (pos == P_LEN)
				len_b = b;
			if (pos == P_LCS)
				lcs_b = b;
			if (pos >= P_DATA && pos < P_DATA + int'(len_b))
				data_sum = data_sum + b;
			if (pos == P_DATA + int'(len_b))
				dcs_b = b;
			if (pos == P_CODE)
				code_b = b;
			if (pos >= P_UID && pos < P_UID + 4)
				uid_b = uid_b | (32'(b) << (8 * (pos - P_UID)));
			rx_count = (pos + 1) & 127;
		end
	endtask

	// Status in priority order: short, length check, window, data checksum
	function automatic rrfc_pkg::status_t judge_frame();
		if (rx_count < MIN_LEN)
			return rrfc_pkg::ST_SHORT;
		if (8'(~len_b + 8'd1) != lcs_b)
			return rrfc_pkg::ST_LCS_BAD;
		if (P_DATA + int'(len_b) >= BUF_BYTES)
			return rrfc_pkg::ST_BEYOND;
		if (8'(~data_sum + 8'd1) != dcs_b)
			return rrfc_pkg::ST_DCS_BAD;
		return rrfc_pkg::ST_OK;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		rrfc_pkg::out_item_t want;
		rrfc_pkg::out_item_t got;
		if (!arst_n) begin
			clear_frame();
			due_results.delete();
			fail_count  = 0;
			pending     = 0;
			n_checked   = 0;
			status_seen = '0;
		end else begin
			// Result transfer: compare with the oldest owed result
			if (out_valid && out_ready) begin
				got = out_data;
				if (due_results.size() == 0) begin
					$display("%t: unexpected result status=%0d code=%h uid=%h", $realtime,
						got.frame_status, got.response_code, got.card_uid);
					fail_count++;
				end else begin
					want = due_results.pop_front();
					n_checked++;
					if (got.frame_status <= rrfc_pkg::ST_BEYOND)
						status_seen[got.frame_status] = 1'b1;
					if (got.frame_status !== want.frame_status) begin
						$display("%t: frame_status expected %0d got %0d", $realtime,
							want.frame_status, got.frame_status);
						fail_count++;
					end
					if (got.response_code !== want.response_code) begin
						$display("%t: response_code expected %h got %h", $realtime,
							want.response_code, got.response_code);
						fail_count++;
					end
					if (got.card_uid !== want.card_uid) begin
						$display("%t: card_uid expected %h got %h", $realtime,
							want.card_uid, got.card_uid);
						fail_count++;
					end
				end
			end
			// Item transfer: a byte updates the captures, a check owes a result
			if (in_valid && in_ready) begin
				if (in_data.req_type == rrfc_pkg::REQ_CHECK) begin
					want.frame_status  = judge_frame();
					want.response_code = code_b;
					want.card_uid      = uid_b;
					due_results.push_back(want);
					clear_frame();
				end else begin
					capture_byte(in_data.rx_byte);
				end
			end
			pending = due_results.size();
		end
	end

endmodule

// ----- sim/tb.sv -----
// Testbench top: clock, reset, frame stimulus, result back-pressure and verdict.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int P_LEN_POS = rrfc_pkg::ACK_BYTES_DEF + 3;

	logic clk;
	logic arst_n;

	rrfc_in_if  item_ch ();
	rrfc_out_if result_ch ();

	int         fail_count;
	int         pending;
	int         n_checked;
	logic [4:0] status_seen;

	int src_idle;
	int snk_idle;
	int n_sent;
	int hold_reqs;
	int phase_start;

	reader_response_frame_checker_unit DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch)
	);

	rrfc_frame_mon mon (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (item_ch.valid),
		.in_ready    (item_ch.ready),
		.in_data     (item_ch.data),
		.out_valid   (result_ch.valid),
		.out_ready   (result_ch.ready),
		.out_data    (result_ch.data),
		.fail_count  (fail_count),
		.pending     (pending),
		.n_checked   (n_checked),
		.status_seen (status_seen)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Run limit, far beyond the slowest correct run
	initial begin
		#1000000;
		$display("reader_response_frame_checker_unit: mismatch");
		$finish;
	end

	// Result side: random stalls, plus a long hold-off on request
	initial begin : result_sink
		int holds_done;
		holds_done = 0;
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_reqs != holds_done) begin
				holds_done++;
				repeat (300) begin
					result_ch.ready <= 1'b0;
					@(negedge clk);
				end
			end
			result_ch.ready <= ($urandom_range(0, 99) >= snk_idle);
		end
	end

	// One item transfer, with random idle cycles ahead of it
	task automatic send_item(input logic req, input logic [7:0] b);
		rrfc_pkg::in_item_t it;
		it.req_type = req;
		it.rx_byte  = b;
		while ($urandom_range(0, 99) < src_idle) begin
			item_ch.valid <= 1'b0;
			@(negedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.data  <= it;
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
		@(negedge clk);
		n_sent++;
	endtask

	// Stop offering items until every owed result has been checked
	task automatic wait_drained();
		item_ch.valid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
	endtask

	// One response stream followed by its check; mostly well-formed frames
	task automatic send_frame();
		logic [7:0] frm[$];
		logic [7:0] sum;
		logic [7:0] b;
		int         kind;
		int         len;
		int         n;
		kind = $urandom_range(0, 99);
		frm.delete();
		if (kind < 88) begin
			// ack frame, preamble and header with random content
			repeat (P_LEN_POS) frm.push_back(8'($urandom));
			if (kind < 70)
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 52)
					: $urandom_range(0, 14);
			else if (kind < 80)
				len = $urandom_range(53, 255);
			else
				len = $urandom_range(0, 10);
			frm.push_back(8'(len));
			if ($urandom_range(0, 9) == 0)
				frm.push_back(8'($urandom));
			else
				frm.push_back(8'(~8'(len) + 8'd1));
			sum = '0;
			for (int i = 0; i < len && frm.size() < 90; i++) begin
				b = 8'($urandom);
				sum = sum + b;
				frm.push_back(b);
			end
			if ($urandom_range(0, 99) < 15)
				frm.push_back(8'($urandom));
			else
				frm.push_back(8'(~sum + 8'd1));
			// trailing bytes; some streams run past the buffer end
			if (kind >= 80)
				n = $urandom_range(60, 80);
			else
				n = frm.size() + $urandom_range(0, 12);
			while (frm.size() < n)
				frm.push_back(8'($urandom));
		end else begin
			// noise: random bytes, often too few
			n = (kind < 94) ? $urandom_range(0, 14) : $urandom_range(15, 40);
			repeat (n) frm.push_back(8'($urandom));
		end
		foreach (frm[i])
			send_item(rrfc_pkg::REQ_BYTE, frm[i]);
		send_item(rrfc_pkg::REQ_CHECK, 8'($urandom));
	endtask

	// Stimulus and verdict
	initial begin : stimulus
		int saved_idle;
		arst_n        = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.data  = '0;
		src_idle      = 9;
		snk_idle      = 64;
		n_sent        = 0;
		hold_reqs     = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: check of an empty stream, all-ones frame, short stream
		send_item(rrfc_pkg::REQ_CHECK, 8'hFF);
		repeat (15) send_item(rrfc_pkg::REQ_BYTE, 8'hFF);
		send_item(rrfc_pkg::REQ_CHECK, 8'h00);
		send_item(rrfc_pkg::REQ_BYTE, 8'h00);
		send_item(rrfc_pkg::REQ_BYTE, 8'h80);
		send_item(rrfc_pkg::REQ_BYTE, 8'h7F);
		send_item(rrfc_pkg::REQ_CHECK, 8'h55);

		for (int ph = 0; ph < 3; ph++) begin
			src_idle = (ph == 0) ? 9 : (ph == 1) ? 64 : 0;
			snk_idle = (ph == 0) ? 64 : (ph == 1) ? 9 : 0;
			phase_start = n_sent;
			while (n_sent - phase_start < 650)
				send_frame();
			wait_drained();
			if (ph == 0) begin
				// Long result hold-off while checks keep coming: fills the block
				hold_reqs++;
				saved_idle = src_idle;
				src_idle = 0;
				repeat (12) send_item(rrfc_pkg::REQ_CHECK, 8'($urandom));
				src_idle = saved_idle;
				wait_drained();
			end
		end

		repeat (10) @(negedge clk);
		$display("run: %0d item transfers, %0d checked results, hold-off and drain pauses done",
			n_sent, n_checked);
		$display("run: statuses seen %b (bit n = status n, ok..beyond)", status_seen);
		if (fail_count == 0) begin
			$display("reader_response_frame_checker_unit: match");
		end else begin
			$display("reader_response_frame_checker_unit: mismatch");
		end
		$finish;
	end

endmodule
